// ----- hdl/thq_pkg.sv -----
// Shared constants and codes for the terrain height query block.
package thq_pkg;

  // Default vertices per side of the stored height grid.
  localparam int GRID_SIDE = 256;

  // Field widths.
  localparam int CODE_W  = 24;  // height code and fraction width
  localparam int WORLD_W = 20;  // signed Q12.8 world coordinate
  localparam int SCALE_W = 24;  // unsigned Q8.16 grid scale
  localparam int VCNT_W  = 9;
  localparam int MAXH_W  = 10;
  localparam int HGT_W   = 22;  // unsigned Q10.12 height
  localparam int IDX_W   = 8;   // load row and column

  // Register reset values.
  localparam logic [SCALE_W-1:0] GRID_SCALE_RST  = 24'd10445;
  localparam logic [VCNT_W-1:0]  GRID_VERTS_RST  = 9'd256;
  localparam logic [MAXH_W-1:0]  PEAK_HEIGHT_RST = 10'd100;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_GRID_SCALE  = 2'd0,
    CFG_GRID_VERTS  = 2'd1,
    CFG_PEAK_HEIGHT = 2'd2
  } cfg_idx_e;

  // Item commands.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

endpackage

// ----- hdl/terrain_height_query.sv -----
// Terrain height query: banked height grid with barycentric interpolation pipeline.
//
// Load words write one 24-bit height code into the grid; query words return the
// height at a world (x, z) position, interpolated over one triangle of its grid
// cell and scaled by the peak-height register over 2^24. Every input word yields
// exactly one output word, in order; loads and outside queries return height
// zero. The block takes one word per clock when the output is drained: it is a
// seven-stage pipeline (scale multiply, grid access, weight select, corner
// multiply, sum, height multiply, output register). The grid sits in four
// single-port banks split by row and column parity, so the four corners of any
// cell are read in the same cycle and a load writes one bank. Loads and queries
// touch the grid in the same stage and in arrival order, so a query always sees
// every earlier load. Stages fill bubbles independently, so input is still taken
// while a result waits, until seven words are held. Grid entries are not cleared
// at reset; query only cells whose corners were loaded. Configuration writes are
// accepted every cycle and take effect at once; change them only while no words
// are in flight.
module terrain_height_query #(
  parameter int GRID_SIDE = thq_pkg::GRID_SIDE
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [thq_pkg::SCALE_W-1:0]         cfg_data_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [thq_pkg::IDX_W-1:0]           grid_row_i,
  input  logic [thq_pkg::IDX_W-1:0]           grid_col_i,
  input  logic [thq_pkg::CODE_W-1:0]          pixel_code_i,
  input  logic signed [thq_pkg::WORLD_W-1:0]  world_x_i,
  input  logic signed [thq_pkg::WORLD_W-1:0]  world_z_i,
  // output words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [thq_pkg::HGT_W-1:0]           height_out_o,
  output logic                                outside_o
);

  localparam int CODE_W = thq_pkg::CODE_W;
  localparam int MAG_W  = thq_pkg::WORLD_W - 1;          // magnitude of a non-negative coord
  localparam int POS_W  = MAG_W + thq_pkg::SCALE_W;      // Q.24 grid position
  localparam int CXW    = POS_W - CODE_W;                // cell index width
  localparam int CLOG_G = $clog2(GRID_SIDE);
  localparam int CW     = (CLOG_G > 1) ? CLOG_G : 1;     // in-grid cell index width
  localparam int HALF   = (GRID_SIDE + 1) / 2;           // bank rows and columns
  localparam int CLOG_H = $clog2(HALF);
  localparam int HW     = (CLOG_H > 1) ? CLOG_H : 1;
  localparam int BD     = HALF * HALF;                   // bank depth
  localparam int CLOG_B = $clog2(BD);
  localparam int AW     = (CLOG_B > 1) ? CLOG_B : 1;
  localparam int CLOG_V = $clog2(GRID_SIDE + 1);
  localparam int VCW    = (CLOG_V > thq_pkg::VCNT_W) ? CLOG_V : thq_pkg::VCNT_W;
  localparam int GCW    = (CLOG_V > thq_pkg::IDX_W) ? CLOG_V : thq_pkg::IDX_W;
  localparam int WW     = CODE_W + 1;                    // barycentric weight width
  localparam int PW     = CODE_W + WW;                   // corner product width
  localparam int SW     = PW + 1;                        // sum of three products
  localparam int CDW    = 2 * CODE_W;                    // interpolated code, Q24.24
  localparam int MW     = CODE_W + thq_pkg::MAXH_W;      // height partial product
  localparam logic [WW-1:0] ONE = WW'(1) << CODE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [thq_pkg::SCALE_W-1:0] grid_scale_q;
  logic [thq_pkg::VCNT_W-1:0]  grid_verts_q;
  logic [thq_pkg::MAXH_W-1:0]  peak_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_scale_q  <= thq_pkg::GRID_SCALE_RST;
      grid_verts_q  <= thq_pkg::GRID_VERTS_RST;
      peak_height_q <= thq_pkg::PEAK_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        thq_pkg::CFG_GRID_SCALE:  grid_scale_q  <= cfg_data_i;
        thq_pkg::CFG_GRID_VERTS:  grid_verts_q  <= cfg_data_i[thq_pkg::VCNT_W-1:0];
        thq_pkg::CFG_PEAK_HEIGHT: peak_height_q <= cfg_data_i[thq_pkg::MAXH_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // vertices per side clamped to the grid size, and the first outside cell index
  logic [VCW-1:0] vc_ext, vc_eff;
  logic [CXW-1:0] cell_lim;
  logic           vc_small;

  assign vc_ext   = VCW'(grid_verts_q);
  assign vc_eff   = (vc_ext > VCW'(GRID_SIDE)) ? VCW'(GRID_SIDE) : vc_ext;
  assign vc_small = vc_eff < VCW'(2);
  assign cell_lim = CXW'(vc_eff) - CXW'(1);

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when empty or when its successor loads
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic en1, en2, en3, en4, en5, en6, en7;

  assign en7 = !v7_q || out_ready_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: scale world coordinates into Q.24 grid positions
  // ---------------------------------------------------------------------------
  logic                                cmd1_q, neg1_q;
  logic [thq_pkg::IDX_W-1:0]           row1_q, col1_q;
  logic [CODE_W-1:0]                   code1_q;
  logic [POS_W-1:0]                    px1_q, pz1_q;
  logic [MAG_W-1:0]                    mag_x, mag_z;

  assign mag_x = world_x_i[MAG_W-1:0];
  assign mag_z = world_z_i[MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q  <= command_i;
      neg1_q  <= world_x_i[thq_pkg::WORLD_W-1] | world_z_i[thq_pkg::WORLD_W-1];
      row1_q  <= grid_row_i;
      col1_q  <= grid_col_i;
      code1_q <= pixel_code_i;
      px1_q   <= POS_W'(mag_x) * POS_W'(grid_scale_q);
      pz1_q   <= POS_W'(mag_z) * POS_W'(grid_scale_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: grid access. Loads write one bank, queries read all four.
  // ---------------------------------------------------------------------------
  logic [CXW-1:0] cx1, cz1;
  logic [CW-1:0]  cxs, czs;
  logic           out1, is_query1, is_load1, load_ok;
  logic           mem_we, mem_re;
  logic [1:0]     wbank;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr [4];

  assign cx1 = px1_q[POS_W-1:CODE_W];
  assign cz1 = pz1_q[POS_W-1:CODE_W];
  assign cxs = cx1[CW-1:0];
  assign czs = cz1[CW-1:0];

  assign is_query1 = (cmd1_q == thq_pkg::CMD_QUERY);
  assign is_load1  = (cmd1_q == thq_pkg::CMD_LOAD);
  assign out1      = neg1_q || vc_small || (cx1 >= cell_lim) || (cz1 >= cell_lim);
  assign load_ok   = (GCW'(row1_q) < GCW'(GRID_SIDE)) && (GCW'(col1_q) < GCW'(GRID_SIDE));

  assign mem_we = en2 && v1_q && is_load1 && load_ok;
  assign mem_re = en2 && v1_q && is_query1 && !out1;

  // bank {row parity, col parity}; entry (row/2)*HALF + col/2
  assign wbank = {row1_q[0], col1_q[0]};

  always_comb begin
    logic [31:0] wa;
    wa    = 32'(row1_q >> 1) * 32'(HALF) + 32'(col1_q >> 1);
    waddr = wa[AW-1:0];
  end

  // each bank holds exactly one corner: pick the cell row/col of its parity
  for (genvar b = 0; b < 4; b++) begin : g_raddr
    localparam logic [1:0] BID = 2'(b);
    logic [CW-1:0] rsel, csel;
    logic [HW-1:0] rh, ch;
    logic [31:0]   ra;
    assign rsel = czs + CW'(czs[0] ^ BID[1]);
    assign csel = cxs + CW'(cxs[0] ^ BID[0]);
    assign rh   = HW'(rsel >> 1);
    assign ch   = HW'(csel >> 1);
    assign ra   = 32'(rh) * 32'(HALF) + 32'(ch);
    assign raddr[b] = ra[AW-1:0];
  end

  logic [CODE_W-1:0] bank_rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CODE_W-1:0] mem [BD];
    logic [CODE_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (mem_we && (wbank == 2'(b))) begin
        mem[waddr] <= code1_q;
      end
      if (mem_re) begin
        rd_q <= mem[raddr[b]];
      end
    end
    assign bank_rd[b] = rd_q;
  end

  logic              zero2_q, out2_q, cx0_2_q, cz0_2_q;
  logic [CODE_W-1:0] fx2_q, fz2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      zero2_q <= !is_query1 || out1;
      out2_q  <= is_query1 && out1;
      cx0_2_q <= cxs[0];
      cz0_2_q <= czs[0];
      fx2_q   <= px1_q[CODE_W-1:0];
      fz2_q   <= pz1_q[CODE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pick the triangle, its corners and barycentric weights
  // ---------------------------------------------------------------------------
  logic [CODE_W-1:0] h00, h10, h01, h11;
  logic [WW-1:0]     fsum, fxw, fzw;
  logic [CODE_W-1:0] ha_d, hb_d, hc_d;
  logic [WW-1:0]     wa_d, wb_d, wc_d;

  assign h00  = bank_rd[{cz0_2_q,  cx0_2_q}];
  assign h10  = bank_rd[{cz0_2_q, ~cx0_2_q}];
  assign h01  = bank_rd[{~cz0_2_q, cx0_2_q}];
  assign h11  = bank_rd[{~cz0_2_q, ~cx0_2_q}];
  assign fxw  = WW'(fx2_q);
  assign fzw  = WW'(fz2_q);
  assign fsum = fxw + fzw;

  always_comb begin
    if (!fsum[CODE_W]) begin
      // lower triangle: origin corner, +x corner, +z corner
      ha_d = h00;  wa_d = ONE - fsum;
      hb_d = h10;  wb_d = fxw;
      hc_d = h01;  wc_d = fzw;
    end else begin
      // upper triangle: +x corner, far corner, +z corner
      ha_d = h10;  wa_d = ONE - fzw;
      hb_d = h11;  wb_d = fsum - ONE;
      hc_d = h01;  wc_d = ONE - fxw;
    end
  end

  logic              zero3_q, out3_q;
  logic [CODE_W-1:0] ha3_q, hb3_q, hc3_q;
  logic [WW-1:0]     wa3_q, wb3_q, wc3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      zero3_q <= zero2_q;
      out3_q  <= out2_q;
      ha3_q   <= ha_d;
      hb3_q   <= hb_d;
      hc3_q   <= hc_d;
      wa3_q   <= wa_d;
      wb3_q   <= wb_d;
      wc3_q   <= wc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: corner products
  // ---------------------------------------------------------------------------
  logic          zero4_q, out4_q;
  logic [PW-1:0] pa4_q, pb4_q, pc4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      zero4_q <= zero3_q;
      out4_q  <= out3_q;
      pa4_q   <= PW'(ha3_q) * PW'(wa3_q);
      pb4_q   <= PW'(hb3_q) * PW'(wb3_q);
      pc4_q   <= PW'(hc3_q) * PW'(wc3_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: interpolated code, Q24.24 (weights sum to one, so below 2^48)
  // ---------------------------------------------------------------------------
  logic           zero5_q, out5_q;
  logic [SW-1:0]  psum;
  logic [CDW-1:0] code5_q;

  assign psum = SW'(pa4_q) + SW'(pb4_q) + SW'(pc4_q);

  always_ff @(posedge clk_i) begin
    if (en5) begin
      zero5_q <= zero4_q;
      out5_q  <= out4_q;
      code5_q <= psum[CDW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: code * peak height, split into high and low halves
  // ---------------------------------------------------------------------------
  logic          zero6_q, out6_q;
  logic [MW-1:0] phi6_q, plo6_q;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      zero6_q <= zero5_q;
      out6_q  <= out5_q;
      phi6_q  <= MW'(code5_q[CDW-1:CODE_W]) * MW'(peak_height_q);
      plo6_q  <= MW'(code5_q[CODE_W-1:0]) * MW'(peak_height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: output register. (phi*2^24 + plo) >> 36 == (phi + plo>>24) >> 12
  // ---------------------------------------------------------------------------
  logic [MW:0]                 hsum;
  logic [thq_pkg::HGT_W-1:0]   height_q;
  logic                        outside_q;

  assign hsum = (MW + 1)'(phi6_q) + (MW + 1)'(plo6_q[MW-1:CODE_W]);

  always_ff @(posedge clk_i) begin
    if (en7) begin
      height_q  <= zero6_q ? '0 : hsum[thq_pkg::HGT_W+11:12];
      outside_q <= out6_q;
    end
  end

  assign out_valid_o  = v7_q;
  assign height_out_o = height_q;
  assign outside_o    = outside_q;

`ifndef SYNTHESIS
  // an outside result never carries a height
  a_outside_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outside_o |-> height_out_o == '0)
    else $error("outside result with nonzero height");

  // a grid word either loads or queries, never both in one cycle
  a_mem_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("bank write and read in the same cycle");

  // input stalls only when the first stage holds a word that cannot move
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && !en2)
    else $error("input stalled with room in the pipeline");

  // a new result comes only from a valid word in stage six
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v6_q))
    else $error("result appeared without a word in stage six");

  // a stalled result holds its value
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(height_out_o) && $stable(outside_o))
    else $error("stalled result changed");
`endif

endmodule
